// ===== rtl/escape_rle_encoder_unit_assert.svh =====
// assertion macros of the escape run-length encoder back end
`ifndef ESCAPE_RLE_ENCODER_UNIT_ASSERT_SVH
`define ESCAPE_RLE_ENCODER_UNIT_ASSERT_SVH

// condition that must hold at every clock edge out of reset
`define ERLE_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("erle assertion failed");

// condition that must hold in the cycle after a trigger
`define ERLE_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("erle assertion failed");

`endif

// ===== rtl/erle_pkg.sv =====
// types, constants and helper functions of the escape run-length encoder
`default_nettype none
package erle_pkg;

  localparam int SYMBOLS = 256;
  localparam int SYM_BITS = 8;
  localparam int FIFO_DEPTH = 4;
  localparam logic [7:0] CHUNK_MAX = 8'd255;
  localparam logic [7:0] LITERAL_LIMIT = 8'd3;

  typedef enum logic [1:0] {
    OP_COUNT    = 2'd0,
    OP_CHOOSE   = 2'd1,
    OP_ENCODE   = 2'd2,
    OP_RESERVED = 2'd3
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic       last_byte;
  } cmd_t;

  // one output group: a triple or one to three literals, bytes[0] goes first
  typedef struct packed {
    logic [1:0]      len;
    logic [2:0][7:0] bytes;
  } grp_t;

  typedef struct packed {
    logic       cnt;
    logic [7:0] addr;
    logic       scan;
  } hist_req_t;

  typedef struct packed {
    logic       idle;
    logic       done;
    logic [7:0] code;
  } hist_rsp_t;

  function automatic grp_t make_triple(logic [7:0] esc, logic [7:0] count, logic [7:0] run);
    grp_t g;
    g.len = 2'd3;
    g.bytes[0] = esc;
    g.bytes[1] = count;
    g.bytes[2] = run;
    return g;
  endfunction

  function automatic grp_t make_flush(logic [7:0] prev, logic [7:0] res, logic chunk,
                                      logic [7:0] esc);
    grp_t g;
    if (chunk || (res > LITERAL_LIMIT) || (prev == esc)) begin
      g = make_triple(esc, res, prev);
    end else begin
      g.len = res[1:0];
      g.bytes = {3{prev}};
    end
    return g;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/erle_front.sv =====
// input stage: takes stream requests, classifies them and drops reserved operations
`default_nettype none
module erle_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [7:0]    s_axis_tdata,  // data_byte[7:0]
  input  wire logic [1:0]    s_axis_tuser,  // operation[1:0]
  input  wire logic          s_axis_tlast,  // final_byte
  input  wire logic          full_i,
  output logic               push_o,
  output erle_pkg::cmd_t     cmd_o
);
  import erle_pkg::*;

  logic vld_q;
  cmd_t cmd_q;
  op_e  op_in;

  assign op_in = op_e'(s_axis_tuser);
  assign push_o = vld_q && !full_i;
  assign s_axis_tready = !vld_q || !full_i;
  assign cmd_o = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      vld_q <= (op_in != OP_RESERVED);
    end else if (push_o) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_q.op <= op_in;
      cmd_q.data <= s_axis_tdata;
      cmd_q.last_byte <= s_axis_tlast;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/erle_fifo.sv =====
// short command queue between the front and the back end
`default_nettype none
module erle_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  erle_pkg::cmd_t     cmd_i,
  output logic               full_o,
  output logic               valid_o,
  output erle_pkg::cmd_t     cmd_o,
  input  wire logic          pop_i
);
  import erle_pkg::*;

  localparam int PTR_BITS = $clog2(FIFO_DEPTH);

  cmd_t                entries_q [FIFO_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q;
  logic [PTR_BITS-1:0] rd_ptr_q;
  logic [PTR_BITS:0]   cnt_q;

  assign full_o = (cnt_q == (PTR_BITS + 1)'(FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/erle_hist.sv =====
// byte histogram: pipelined saturating counts and a one-entry-a-cycle minimum scan
`default_nettype none
module erle_hist #(
  parameter int COUNT_BITS = 32
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  erle_pkg::hist_req_t req_i,
  output erle_pkg::hist_rsp_t rsp_o
);
  import erle_pkg::*;

  logic [COUNT_BITS-1:0] mem_q [SYMBOLS];
  logic [SYMBOLS-1:0]    valid_q;

  logic                  rd_en;
  logic [SYM_BITS-1:0]   rd_addr;
  logic [COUNT_BITS-1:0] rdata_q;
  logic                  rval_q;

  logic                  s1_vld_q;
  logic [SYM_BITS-1:0]   s1_addr_q;
  logic                  wr_vld_q;
  logic [SYM_BITS-1:0]   wr_addr_q;
  logic [COUNT_BITS-1:0] wr_val_q;
  logic [COUNT_BITS-1:0] old_val;
  logic [COUNT_BITS-1:0] upd_val;

  logic                  scan_q;
  logic [SYM_BITS:0]     scan_cnt_q;
  logic                  rd_pend_q;
  logic [SYM_BITS-1:0]   rd_idx_q;
  logic [COUNT_BITS-1:0] best_val_q;
  logic [SYM_BITS-1:0]   best_idx_q;
  logic                  done_q;
  logic [SYM_BITS-1:0]   code_q;
  logic [COUNT_BITS-1:0] cur_val;
  logic                  take;
  logic                  last_cmp;

  assign rd_en = req_i.cnt || (scan_q && !scan_cnt_q[SYM_BITS]);
  assign rd_addr = scan_q ? scan_cnt_q[SYM_BITS-1:0] : req_i.addr;

  // the write of the previous edge is not yet in the read data
  assign old_val = (wr_vld_q && (wr_addr_q == s1_addr_q)) ? wr_val_q :
                   (rval_q ? rdata_q : '0);
  assign upd_val = (&old_val) ? old_val : old_val + 1'b1;

  assign cur_val = rval_q ? rdata_q : '0;
  assign take = (rd_idx_q == '0) || (cur_val < best_val_q);
  assign last_cmp = rd_pend_q && (rd_idx_q == SYM_BITS'(SYMBOLS - 1));

  assign rsp_o.idle = !s1_vld_q && !scan_q;
  assign rsp_o.done = done_q;
  assign rsp_o.code = code_q;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
    if (s1_vld_q) begin
      mem_q[s1_addr_q] <= upd_val;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_addr_q <= req_i.addr;
    wr_addr_q <= s1_addr_q;
    wr_val_q <= upd_val;
    rd_idx_q <= scan_cnt_q[SYM_BITS-1:0];
    if (rd_pend_q && take) begin
      best_val_q <= cur_val;
      best_idx_q <= rd_idx_q;
    end
    if (last_cmp) begin
      code_q <= take ? rd_idx_q : best_idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rval_q <= 1'b0;
      s1_vld_q <= 1'b0;
      wr_vld_q <= 1'b0;
      scan_q <= 1'b0;
      scan_cnt_q <= '0;
      rd_pend_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      if (rd_en) begin
        rval_q <= valid_q[rd_addr];
      end
      s1_vld_q <= req_i.cnt;
      wr_vld_q <= s1_vld_q;
      rd_pend_q <= scan_q && !scan_cnt_q[SYM_BITS];
      done_q <= last_cmp;
      if (req_i.scan) begin
        scan_q <= 1'b1;
        scan_cnt_q <= '0;
      end else if (scan_q && !scan_cnt_q[SYM_BITS]) begin
        scan_cnt_q <= scan_cnt_q + 1'b1;
      end
      // entries not written since the last choice read as zero
      if (last_cmp) begin
        scan_q <= 1'b0;
        valid_q <= '0;
      end else if (s1_vld_q) begin
        valid_q[s1_addr_q] <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/erle_back.sv =====
// back end: run tracking, escape choice sequencing and byte emission
`default_nettype none
`include "escape_rle_encoder_unit_assert.svh"
module erle_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cmd_valid_i,
  input  erle_pkg::cmd_t      cmd_i,
  output logic                cmd_pop_o,
  output erle_pkg::hist_req_t hist_req_o,
  input  erle_pkg::hist_rsp_t hist_rsp_i,
  output logic                m_axis_tvalid,
  input  wire logic           m_axis_tready,
  output logic [7:0]          m_axis_tdata,  // out_byte[7:0]
  output logic                m_axis_tuser,  // stream_end
  output logic                m_axis_tlast   // last_of_item
);
  import erle_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] st_q;
  logic       seen_q;
  logic [7:0] esc_q;
  logic       have_prev_q;
  logic [7:0] prev_q;
  logic [7:0] res_q;
  logic       chunk_q;

  grp_t       g0_q;
  grp_t       g1_q;
  logic       g1_vld_q;
  logic       gsel_q;
  logic [1:0] idx_q;
  logic       fin_q;

  logic       out_vld_q;
  logic [7:0] out_data_q;
  logic       out_last_q;
  logic       out_user_q;

  logic       same;
  logic [7:0] res_inc;
  logic       chunk_now;
  logic [7:0] prev_n;
  logic [7:0] res_n;
  logic       chunk_n;
  grp_t       grp_a;
  grp_t       grp_b;
  logic       grp_a_vld;
  grp_t       esc_grp;

  grp_t       cur;
  logic       out_free;
  logic       emit;
  logic       last_grp;
  logic       last_item;

  assign cmd_pop_o = (st_q == ST_IDLE) && cmd_valid_i &&
                     ((cmd_i.op != OP_CHOOSE) || hist_rsp_i.idle);
  assign hist_req_o.cnt = cmd_pop_o && (cmd_i.op == OP_COUNT);
  assign hist_req_o.addr = cmd_i.data;
  assign hist_req_o.scan = cmd_pop_o && (cmd_i.op == OP_CHOOSE);

  always_comb begin
    same = have_prev_q && (cmd_i.data == prev_q);
    res_inc = res_q + 8'd1;
    chunk_now = same && (res_inc == CHUNK_MAX);
    if (same) begin
      grp_a_vld = chunk_now;
      grp_a = make_triple(esc_q, CHUNK_MAX, prev_q);
      prev_n = prev_q;
      res_n = chunk_now ? 8'd0 : res_inc;
      chunk_n = chunk_q || chunk_now;
    end else begin
      grp_a_vld = have_prev_q;
      grp_a = make_flush(prev_q, res_q, chunk_q, esc_q);
      prev_n = cmd_i.data;
      res_n = 8'd1;
      chunk_n = 1'b0;
    end
    // flush of the run as it stands after this byte
    grp_b = make_flush(prev_n, res_n, chunk_n, esc_q);
    esc_grp.len = 2'd1;
    esc_grp.bytes = {3{hist_rsp_i.code}};
  end

  assign cur = gsel_q ? g1_q : g0_q;
  assign out_free = !out_vld_q || m_axis_tready;
  assign emit = (st_q == ST_EMIT) && out_free;
  assign last_grp = (idx_q == (cur.len - 2'd1));
  assign last_item = last_grp && (gsel_q || !g1_vld_q);

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata = out_data_q;
  assign m_axis_tuser = out_user_q;
  assign m_axis_tlast = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      seen_q <= 1'b0;
      esc_q <= 8'd0;
      have_prev_q <= 1'b0;
      prev_q <= 8'd0;
      res_q <= 8'd0;
      chunk_q <= 1'b0;
      g1_vld_q <= 1'b0;
      gsel_q <= 1'b0;
      idx_q <= 2'd0;
      fin_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      case (st_q)
        ST_IDLE: begin
          if (cmd_pop_o) begin
            case (cmd_i.op)
              OP_COUNT: begin
                seen_q <= 1'b1;
              end
              OP_CHOOSE: begin
                have_prev_q <= 1'b0;
                prev_q <= 8'd0;
                res_q <= 8'd0;
                chunk_q <= 1'b0;
                st_q <= ST_SCAN;
              end
              OP_ENCODE: begin
                if (cmd_i.last_byte) begin
                  have_prev_q <= 1'b0;
                  prev_q <= 8'd0;
                  res_q <= 8'd0;
                  chunk_q <= 1'b0;
                end else begin
                  have_prev_q <= 1'b1;
                  prev_q <= prev_n;
                  res_q <= res_n;
                  chunk_q <= chunk_n;
                end
                g1_vld_q <= grp_a_vld && cmd_i.last_byte;
                fin_q <= cmd_i.last_byte;
                gsel_q <= 1'b0;
                idx_q <= 2'd0;
                if (grp_a_vld || cmd_i.last_byte) begin
                  st_q <= ST_EMIT;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (hist_rsp_i.done) begin
            esc_q <= hist_rsp_i.code;
            seen_q <= 1'b0;
            g1_vld_q <= 1'b0;
            fin_q <= 1'b0;
            gsel_q <= 1'b0;
            idx_q <= 2'd0;
            st_q <= seen_q ? ST_EMIT : ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (emit) begin
            if (last_item) begin
              st_q <= ST_IDLE;
            end else if (last_grp) begin
              gsel_q <= 1'b1;
              idx_q <= 2'd0;
            end else begin
              idx_q <= idx_q + 2'd1;
            end
          end
        end
        default: begin
          st_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if ((st_q == ST_IDLE) && cmd_pop_o && (cmd_i.op == OP_ENCODE)) begin
      g0_q <= grp_a_vld ? grp_a : grp_b;
      g1_q <= grp_b;
    end else if ((st_q == ST_SCAN) && hist_rsp_i.done) begin
      g0_q <= esc_grp;
    end
    if (emit) begin
      out_data_q <= cur.bytes[idx_q];
      out_last_q <= last_item;
      out_user_q <= last_item && fin_q;
    end
  end

  `ERLE_ASSERT(a_end_is_last, !out_vld_q || !out_user_q || out_last_q)
  `ERLE_ASSERT(a_scan_when_idle, !hist_req_o.scan || hist_rsp_i.idle)
  `ERLE_ASSERT(a_idx_in_group, (st_q != ST_EMIT) || (idx_q < cur.len))
  `ERLE_ASSERT_NEXT(a_scan_leaves, (st_q == ST_SCAN) && hist_rsp_i.done, st_q != ST_SCAN)

endmodule
`default_nettype wire

// ===== rtl/escape_rle_encoder_unit.sv =====
// top level of the two-pass escape byte run-length encoder
//
// Usage: one input stream carries requests. tuser holds the operation
// (count, choose escape, encode), tdata the byte and tlast the final-byte
// flag of the encode pass. The output stream carries one encoded byte per
// beat; tlast marks the last byte caused by a request and tuser the last
// byte of the encoded stream.
// Requests pass an input register and a four-deep queue before the back end.
// Count requests go at one per cycle, while the back end is idle, into a
// read-modify-write histogram pipeline with forwarding. An encode request
// emits zero to six bytes and holds the back end until the last of them
// is loaded into the output register, which every byte passes on its way out.
// A choose request waits for the count pipeline to drain, then scans the
// 256 histogram entries at one memory read per cycle.
// Reset clears all control state and the histogram valid bits at once,
// so no clearing pass follows reset. When the receiver stalls, the output
// register holds its byte, the back end waits, the queue fills and
// s_axis_tready falls.
`default_nettype none
module escape_rle_encoder_unit #(
  parameter int COUNT_BITS = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,  // data_byte[7:0]
  input  wire logic [1:0] s_axis_tuser,  // operation[1:0]
  input  wire logic       s_axis_tlast,  // final_byte
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,  // out_byte[7:0]
  output logic            m_axis_tuser,  // stream_end
  output logic            m_axis_tlast   // last_of_item
);
  import erle_pkg::*;

  logic      push;
  logic      full;
  cmd_t      front_cmd;
  logic      q_valid;
  cmd_t      q_cmd;
  logic      pop;
  hist_req_t hist_req;
  hist_rsp_t hist_rsp;

  erle_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .full_i        (full),
    .push_o        (push),
    .cmd_o         (front_cmd)
  );

  erle_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .valid_o (q_valid),
    .cmd_o   (q_cmd),
    .pop_i   (pop)
  );

  erle_hist #(
    .COUNT_BITS (COUNT_BITS)
  ) u_hist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (hist_req),
    .rsp_o  (hist_rsp)
  );

  erle_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (q_valid),
    .cmd_i         (q_cmd),
    .cmd_pop_o     (pop),
    .hist_req_o    (hist_req),
    .hist_rsp_i    (hist_rsp),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// testbench for the escape run-length encoder: random request streams checked against a predictor
`timescale 1ns / 1ps
module tb_top;
  import erle_pkg::*;

  localparam int COUNT_BITS = 32;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_OFF = 12;
  localparam int DRAIN_CYCLES = 400;
  localparam int SHORT_ITEMS = 350;

  typedef struct {
    op_e        op;
    logic [7:0] data;
    logic       fin;
    logic       hold;
  } enc_request_t;

  typedef struct packed {
    logic [7:0] value;
    logic       item_end;
    logic       stream_end;
  } out_beat_t;

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic [1:0] s_axis_tuser = OP_COUNT;
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tuser;
  logic       m_axis_tlast;

  escape_rle_encoder_unit #(
    .COUNT_BITS(COUNT_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  enc_request_t pending_requests[$];
  out_beat_t    expected_bytes[$];
  logic [7:0]   item_bytes[$];
  int           total_items;
  int           sent_cnt = 0;
  int           taken_cnt = 0;
  int           quiet_cycles = 0;
  int           mismatches = 0;

  // predictor state
  logic [COUNT_BITS-1:0] sym_count[SYMBOLS];
  logic                  counted_any;
  logic [7:0]            esc_byte;
  logic                  run_open;
  logic [7:0]            run_byte;
  logic [7:0]            run_len_mod;
  logic                  run_chunked;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic drop_run();
    run_open = 1'b0;
    run_byte = 8'h00;
    run_len_mod = 8'h00;
    run_chunked = 1'b0;
  endtask

  task automatic emit_triple(input logic [7:0] count);
    item_bytes.push_back(esc_byte);
    item_bytes.push_back(count);
    item_bytes.push_back(run_byte);
  endtask

  task automatic flush_pending();
    if (!run_open) return;
    if (run_chunked || run_len_mod > LITERAL_LIMIT || run_byte == esc_byte) begin
      emit_triple(run_len_mod);
    end else begin
      repeat (run_len_mod) item_bytes.push_back(run_byte);
    end
  endtask

  task automatic predict_request(input op_e op, input logic [7:0] b, input logic fin);
    int best;
    item_bytes = {};
    case (op)
      OP_COUNT: begin
        if (sym_count[b] != '1) sym_count[b] = sym_count[b] + 1'b1;
        counted_any = 1'b1;
      end
      OP_CHOOSE: begin
        best = 0;
        for (int i = 1; i < SYMBOLS; i++) begin
          if (sym_count[i] < sym_count[best]) best = i;
        end
        esc_byte = best[7:0];
        if (counted_any) item_bytes.push_back(esc_byte);
        foreach (sym_count[i]) sym_count[i] = '0;
        counted_any = 1'b0;
        drop_run();
      end
      OP_ENCODE: begin
        if (run_open && b == run_byte) begin
          run_len_mod = run_len_mod + 1'b1;
          if (run_len_mod >= CHUNK_MAX) begin
            emit_triple(CHUNK_MAX);
            run_len_mod = 8'h00;
            run_chunked = 1'b1;
          end
        end else begin
          flush_pending();
          run_open = 1'b1;
          run_byte = b;
          run_len_mod = 8'd1;
          run_chunked = 1'b0;
        end
        if (fin) begin
          flush_pending();
          drop_run();
        end
      end
      default: ;
    endcase
    foreach (item_bytes[i]) begin
      expected_bytes.push_back('{item_bytes[i], i == item_bytes.size() - 1,
                                 i == item_bytes.size() - 1 && op == OP_ENCODE && fin});
    end
  endtask

  task automatic log_mismatch(input string what, input out_beat_t want, input out_beat_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch (%s): expected %02h last %0b end %0b, got %02h last %0b end %0b",
               what, want.value, want.item_end, want.stream_end,
               got.value, got.item_end, got.stream_end);
    end
  endtask

  task automatic add_req(input op_e op, input logic [7:0] d, input logic fin,
                         input logic hold);
    pending_requests.push_back('{op, d, fin, hold});
  endtask

  // count pass, escape choice and an encode pass; some streams are left unfinished
  task automatic add_session(input int long_len, inout int short_used);
    logic [7:0]   alphabet[5];
    logic [255:0] counted;
    logic [7:0]   esc_guess;
    logic [7:0]   sym;
    logic         first;
    logic         broken;
    logic         fin;
    logic         long_run;
    int           n_sym;
    int           n_cnt;
    int           n_runs;
    int           len;
    counted = '0;
    first = 1'b1;
    n_sym = $urandom_range(1, 5);
    foreach (alphabet[i]) alphabet[i] = 8'($urandom_range(0, 255));
    if ($urandom_range(3) == 0) alphabet[0] = 8'h00;
    if ($urandom_range(5) == 0) alphabet[n_sym - 1] = 8'hff;
    n_cnt = ($urandom_range(5) == 0) ? 0 : $urandom_range(1, 14);
    for (int i = 0; i < n_cnt; i++) begin
      sym = alphabet[$urandom_range(n_sym - 1)];
      counted[sym] = 1'b1;
      add_req(OP_COUNT, sym, 1'($urandom_range(1)), first);
      first = 1'b0;
      short_used++;
      if ($urandom_range(9) == 0) begin
        add_req(OP_RESERVED, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0);
      end
    end
    add_req(OP_CHOOSE, 8'($urandom_range(255)), 1'($urandom_range(1)), first);
    short_used++;
    // escape will be the lowest byte that was not counted
    esc_guess = 8'h00;
    for (int v = 255; v >= 0; v--) begin
      if (!counted[v]) esc_guess = v[7:0];
    end
    broken = ($urandom_range(7) == 0);
    n_runs = $urandom_range(1, 8);
    for (int r = 0; r < n_runs; r++) begin
      case ($urandom_range(9))
        0, 1, 2: sym = esc_guess;
        3:       sym = 8'($urandom_range(255));
        default: sym = alphabet[$urandom_range(n_sym - 1)];
      endcase
      long_run = (long_len > 0) && (r == 0);
      len = ($urandom_range(2) == 0) ? $urandom_range(4, 7) : $urandom_range(1, 3);
      if (long_run) len = long_len;
      for (int k = 0; k < len; k++) begin
        // a long run is kept whole so that it crosses the full-chunk boundary
        fin = (r == n_runs - 1 && k == len - 1 && !broken) ||
              (!long_run && $urandom_range(39) == 0);
        add_req(OP_ENCODE, sym, fin, 1'b0);
        if (!long_run) short_used++;
      end
      if ($urandom_range(11) == 0) begin
        add_req(OP_RESERVED, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0);
      end
    end
  endtask

  // sender side and receiver ready, both change at the falling edge
  always @(negedge clk_i) begin
    int ph;
    int tx_idle;
    int rx_idle;
    enc_request_t req;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      ph = (taken_cnt * 3 < total_items) ? 0 : (taken_cnt * 3 < total_items * 2) ? 1 : 2;
      tx_idle = (ph == 0) ? 26 : (ph == 1) ? 53 : 0;
      rx_idle = (ph == 0) ? 53 : (ph == 1) ? 26 : 0;
      if (expected_bytes.size() != 0) quiet_cycles = 0;
      else if (quiet_cycles < HOLD_OFF) quiet_cycles++;
      m_axis_tready <= ($urandom_range(99) >= rx_idle);
      if (sent_cnt == taken_cnt) begin
        if (pending_requests.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (pending_requests[0].hold && quiet_cycles < HOLD_OFF) begin
          s_axis_tvalid <= 1'b0;
        end else if ($urandom_range(99) < tx_idle) begin
          s_axis_tvalid <= 1'b0;
        end else begin
          req = pending_requests.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= req.op;
          s_axis_tdata <= req.data;
          s_axis_tlast <= req.fin;
          sent_cnt++;
        end
      end
    end
  end

  // request intake and result checking at the rising edge
  always @(posedge clk_i) begin
    out_beat_t got;
    out_beat_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_request(op_e'(s_axis_tuser), s_axis_tdata, s_axis_tlast);
        taken_cnt++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata, m_axis_tlast, m_axis_tuser};
        if (expected_bytes.size() == 0) begin
          log_mismatch("no byte expected", '0, got);
        end else begin
          want = expected_bytes.pop_front();
          if (got.value !== want.value) log_mismatch("byte", want, got);
          else if (got.item_end !== want.item_end) log_mismatch("tlast", want, got);
          else if (got.stream_end !== want.stream_end) log_mismatch("tuser", want, got);
        end
      end
    end
  end

  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) stuck = 0;
      else stuck++;
    end
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    int short_used;
    int session;
    foreach (sym_count[i]) sym_count[i] = '0;
    counted_any = 1'b0;
    esc_byte = 8'h00;
    drop_run();

    // directed: reserved op, empty choose, encode before any counting
    add_req(OP_RESERVED, 8'hff, 1'b1, 1'b0);
    add_req(OP_CHOOSE, 8'h00, 1'b1, 1'b0);
    add_req(OP_ENCODE, 8'h00, 1'b1, 1'b0);
    add_req(OP_ENCODE, 8'hff, 1'b1, 1'b0);
    repeat (2) add_req(OP_ENCODE, 8'h7f, 1'b0, 1'b0);
    add_req(OP_ENCODE, 8'h7f, 1'b1, 1'b0);
    // count pass with a final flag that must be ignored
    add_req(OP_COUNT, 8'h10, 1'b0, 1'b1);
    add_req(OP_COUNT, 8'h10, 1'b0, 1'b0);
    add_req(OP_COUNT, 8'hff, 1'b1, 1'b0);
    add_req(OP_COUNT, 8'h00, 1'b0, 1'b0);
    add_req(OP_CHOOSE, 8'h00, 1'b1, 1'b0);
    repeat (4) add_req(OP_ENCODE, 8'h05, 1'b0, 1'b0);
    repeat (3) add_req(OP_ENCODE, 8'h07, 1'b0, 1'b0);
    add_req(OP_ENCODE, 8'h01, 1'b0, 1'b0);
    add_req(OP_ENCODE, 8'h09, 1'b0, 1'b0);
    add_req(OP_RESERVED, 8'h00, 1'b0, 1'b0);
    // choose in the middle of an encode drops the pending run
    add_req(OP_CHOOSE, 8'h5a, 1'b0, 1'b0);

    // one session carries a run long enough for a full chunk
    short_used = 0;
    session = 0;
    while (pending_requests.size() < SHORT_ITEMS || session < 3) begin
      if (session == 1) add_session($urandom_range(255, 258), short_used);
      else add_session(0, short_used);
      session++;
    end
    total_items = pending_requests.size();

    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (taken_cnt < total_items || expected_bytes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    mismatches += expected_bytes.size();
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
